// ===== rtl/core/bdhr_pkg.sv =====
`default_nettype none
package bdhr_pkg;

   // number of debounce lanes, and of buttons that reach the event ports
   localparam int BUTTONS    = 4;
   localparam int OUT_EVENTS = 4;

   localparam int DEB_W  = 10;
   localparam int HOLD_W = 12;
   localparam int CNT_W  = 14;
   localparam int PIN_W  = 4;
   localparam int EV_W   = 3;

   // csr data is as wide as the widest register
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(20);
   localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(500);
   localparam logic [PIN_W-1:0]  REP_RESET  = PIN_W'(3);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_REPEAT   = 2'd2
   } reg_index_type;

   typedef enum logic [EV_W-1:0] {
      EV_NONE         = 3'd0,
      EV_PRESS        = 3'd1,
      EV_RELEASE      = 3'd2,
      EV_HOLDING      = 3'd3,
      EV_HOLD_RELEASE = 3'd4
   } event_type;

   // timing settings shared by all lanes
   typedef struct packed {
      logic [DEB_W-1:0]  debounce;
      logic [HOLD_W-1:0] hold;
   } timing_type;

endpackage
`default_nettype wire

// ===== rtl/core/bdhr_lane.sv =====
`default_nettype none
module bdhr_lane
   import bdhr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       pressed,
   input  wire logic       rep_en,
   input  wire timing_type timing,
   output event_type       lane_event
);

   logic signed [CNT_W-1:0] count_ff;
   logic signed [CNT_W-1:0] count_in;
   logic signed [CNT_W-1:0] deb_s;
   logic signed [CNT_W-1:0] hold_s;
   logic signed [CNT_W-1:0] count_inc;

   assign deb_s     = signed'({{(CNT_W-DEB_W){1'b0}}, timing.debounce});
   assign hold_s    = signed'({{(CNT_W-HOLD_W){1'b0}}, timing.hold});
   assign count_inc = count_ff + CNT_W'(1);

   // ordered phase tests, first match decides
   always_comb begin
      count_in   = count_ff;
      lane_event = EV_NONE;
      if (count_ff == '0) begin
         if (pressed) begin
            lane_event = EV_PRESS;
            count_in   = CNT_W'(1);
         end
      end else if (count_ff > 0 && count_ff < deb_s) begin
         count_in = count_inc;
      end else if (count_ff >= deb_s && count_ff < hold_s) begin
         if (!pressed) begin
            lane_event = EV_RELEASE;
            count_in   = -deb_s;
         end else begin
            count_in = count_inc;
         end
      end else if (count_ff == hold_s) begin
         count_in = count_inc;
      end else if (count_ff > hold_s) begin
         if (pressed) begin
            if (rep_en) begin
               lane_event = EV_HOLDING;
            end
         end else begin
            lane_event = EV_HOLD_RELEASE;
            count_in   = -deb_s;
         end
      end else begin
         // release lockout climbs back to zero
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bdhr_merge.sv =====
`default_nettype none
module bdhr_merge
   import bdhr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire logic      take,
   input  wire event_type lane_event [BUTTONS],
   output logic           out_valid,
   output event_type      out_event [OUT_EVENTS],
   output logic           out_any
);

   event_type ev_sel [OUT_EVENTS];
   event_type ev_ff  [OUT_EVENTS];
   logic      any_in;
   logic      any_ff;
   logic      valid_ff;

   // buttons past the lane count report nothing
   for (genvar k = 0; k < OUT_EVENTS; k++) begin : g_sel
      if (k < BUTTONS) begin : g_lane
         assign ev_sel[k] = lane_event[k];
      end else begin : g_none
         assign ev_sel[k] = EV_NONE;
      end
   end

   always_comb begin
      any_in = 1'b0;
      for (int k = 0; k < OUT_EVENTS; k++) begin
         any_in = any_in | (ev_sel[k] != EV_NONE);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff  <= ev_sel;
         any_ff <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   assign out_valid = valid_ff;
   assign out_event = ev_ff;
   assign out_any   = any_ff;

endmodule
`default_nettype wire

// ===== rtl/core/button_debounce_hold_repeat_unit.sv =====
// Button debouncer with hold detection and hold repeat, four buttons.
// Request channel (req_valid/req_ready): one transfer per tick, carrying
// req_pin_levels, the raw active-low button levels (bit b = button b).
// Response channel (rsp_valid/rsp_ready): one transfer per request with the
// event code of each button (0 none, 1 press, 2 release, 3 holding,
// 4 hold release) and rsp_any_event.
// The response is valid the cycle after the request transfer. Throughput is
// one request per cycle while responses are taken; each button lane does one
// compare-and-step on its counter per tick, all lanes in parallel.
// The result register frees in the same cycle its transfer completes, so a
// new request is taken while the response drains; if the receiver stalls,
// req_ready drops until the waiting response is taken.
// CSR port (csr_valid/csr_ready, always ready): index 0 debounce ticks,
// 1 hold ticks, 2 repeat mask; other indexes are ignored. Write only when
// no request is in flight.
// Reset clears all counters and the response valid, and loads debounce 20,
// hold 500, repeat mask 3.
`default_nettype none
module button_debounce_hold_repeat_unit
   import bdhr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [PIN_W-1:0]       req_pin_levels,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [EV_W-1:0]             rsp_event_up,
   output logic [EV_W-1:0]             rsp_event_down,
   output logic [EV_W-1:0]             rsp_event_settings,
   output logic [EV_W-1:0]             rsp_event_enter,
   output logic                        rsp_any_event,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [DEB_W-1:0]  deb_ff;
   logic [HOLD_W-1:0] hold_ff;
   logic [PIN_W-1:0]  rep_ff;
   timing_type        timing;
   logic              req_xfer;
   logic              rsp_xfer;
   event_type         lane_event [BUTTONS];
   event_type         out_event  [OUT_EVENTS];

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff  <= DEB_RESET;
         hold_ff <= HOLD_RESET;
         rep_ff  <= REP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEBOUNCE: deb_ff  <= csr_data[DEB_W-1:0];
            REG_HOLD:     hold_ff <= csr_data[HOLD_W-1:0];
            REG_REPEAT:   rep_ff  <= csr_data[PIN_W-1:0];
            default:      ;
         endcase
      end
   end

   assign timing.debounce = deb_ff;
   assign timing.hold     = hold_ff;

   // take a request whenever the result register is free or draining
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // one lane per button; lanes past the pin count never see a press
   for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
      logic lane_pressed;
      logic lane_rep;
      if (b < PIN_W) begin : g_pin
         assign lane_pressed = !req_pin_levels[b];
         assign lane_rep     = rep_ff[b];
      end else begin : g_nopin
         assign lane_pressed = 1'b0;
         assign lane_rep     = 1'b0;
      end
      bdhr_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .advance    (req_xfer),
         .pressed    (lane_pressed),
         .rep_en     (lane_rep),
         .timing     (timing),
         .lane_event (lane_event[b])
      );
   end

   bdhr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (req_xfer),
      .take       (rsp_xfer),
      .lane_event (lane_event),
      .out_valid  (rsp_valid),
      .out_event  (out_event),
      .out_any    (rsp_any_event)
   );

   assign rsp_event_up       = out_event[0];
   assign rsp_event_down     = out_event[1];
   assign rsp_event_settings = out_event[2];
   assign rsp_event_enter    = out_event[3];

endmodule
`default_nettype wire
